@@ rtl/srs_pkg.sv @@
package srs_pkg;

  localparam int CHAR_W      = 8;
  localparam int PATTERN_MAX = 8;
  localparam int REPL_MAX    = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int PLEN_W = 4;
  localparam int RLEN_W = 5;
  localparam int WORD_W = 64;
  localparam int IDX_W  = 3;
  localparam int POS_W  = 5;

  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PLEN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_PAT   = 3'd2;
  localparam logic [IDX_W-1:0] REG_RLEN  = 3'd3;
  localparam logic [IDX_W-1:0] REG_RLOW  = 3'd4;
  localparam logic [IDX_W-1:0] REG_RHIGH = 3'd5;

  localparam logic [1:0] MODE_REPLACE = 2'd1;
  localparam logic [1:0] MODE_SPACE   = 2'd2;

  // what the head of a request emits
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_REPL  = 2'd2;
  localparam logic [1:0] KIND_SPACE = 2'd3;

  typedef struct packed {
    logic [1:0]                          mode;
    logic [PLEN_W-1:0]                   plen;
    logic [PATTERN_MAX-1:0][CHAR_W-1:0]  pattern;
    logic [RLEN_W-1:0]                   rlen;
    logic [REPL_MAX-1:0][CHAR_W-1:0]     repl;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                          kind;
    logic [CHAR_W-1:0]                   head_char;
    logic                                last;
    logic [PLEN_W-1:0]                   flush_cnt;
    logic [PATTERN_MAX-1:0][CHAR_W-1:0]  flush_bytes;
  } cmd_t;

  function automatic logic [PLEN_W-1:0] eff_plen(input logic [PLEN_W-1:0] raw);
    logic [PLEN_W-1:0] n;
    n = raw;
    if (n == '0) n = PLEN_W'(1);
    if (n > PLEN_W'(PATTERN_MAX)) n = PLEN_W'(PATTERN_MAX);
    return n;
  endfunction

  function automatic logic [RLEN_W-1:0] eff_rlen(input logic [RLEN_W-1:0] raw);
    logic [RLEN_W-1:0] n;
    n = raw;
    if (n > RLEN_W'(REPL_MAX)) n = RLEN_W'(REPL_MAX);
    return n;
  endfunction

endpackage

@@ rtl/srs_queue.sv @@
module srs_queue #(
  parameter int DEPTH = srs_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  srs_pkg::cmd_t din,
  input  logic          pop,
  output srs_pkg::cmd_t dout,
  output logic          full,
  output logic          empty
);
  import srs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ rtl/srs_front.sv @@
module srs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [srs_pkg::CHAR_W-1:0]  in_tdata,
  input  logic                        in_tlast,
  input  srs_pkg::cfg_t               cfg,
  input  logic                        wnd_clear,
  input  logic                        q_full,
  output logic                        q_push,
  output srs_pkg::cmd_t               q_data
);
  import srs_pkg::*;

  logic [PATTERN_MAX-1:0][CHAR_W-1:0] wnd_r, wnd_nxt;
  logic [PLEN_W-1:0]                  count_r, count_nxt;

  logic [PATTERN_MAX-1:0][CHAR_W-1:0] wnd_new;
  logic [PLEN_W-1:0]                  cnt_new;
  logic                               match;
  logic                               accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign q_push    = accept;

  always_comb begin
    wnd_new = wnd_r;
    cnt_new = count_r;
    if (count_r < PLEN_W'(PATTERN_MAX)) begin
      wnd_new[count_r[$clog2(PATTERN_MAX)-1:0]] = in_tdata;
      cnt_new = count_r + PLEN_W'(1);
    end

    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((PLEN_W'(i) < cfg.plen) && (wnd_new[i] != cfg.pattern[i])) match = 1'b0;
    end

    q_data           = '0;
    q_data.kind      = KIND_NONE;
    q_data.head_char = wnd_new[0];
    q_data.last      = in_tlast;
    wnd_nxt          = wnd_new;
    count_nxt        = cnt_new;

    if (cnt_new >= cfg.plen) begin
      if (match) begin
        count_nxt = '0;
        if (cfg.mode == MODE_REPLACE) begin
          q_data.kind = KIND_REPL;
        end else if (cfg.mode == MODE_SPACE) begin
          q_data.kind = KIND_SPACE;
        end
      end else begin
        q_data.kind = KIND_CHAR;
        for (int i = 0; i < PATTERN_MAX - 1; i++) begin
          wnd_nxt[i] = wnd_new[i+1];
        end
        count_nxt = cnt_new - PLEN_W'(1);
      end
    end

    // token end hands the remaining window to the back end
    q_data.flush_bytes = wnd_nxt;
    q_data.flush_cnt   = in_tlast ? count_nxt : '0;
    if (in_tlast) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (wnd_clear) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wnd_r <= wnd_nxt;
    end
  end

endmodule

@@ rtl/srs_back.sv @@
module srs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  srs_pkg::cfg_t               cfg,
  input  logic                        q_empty,
  input  srs_pkg::cmd_t               q_data,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [srs_pkg::CHAR_W-1:0]  out_tdata,
  output logic                        out_tlast
);
  import srs_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic [POS_W-1:0]  head_n, total_n, flush_pos;
  logic              can_emit, busy;
  logic [CHAR_W-1:0] item_char;
  logic              item_last;

  assign can_emit   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    case (q_data.kind)
      KIND_CHAR:  head_n = POS_W'(1);
      KIND_SPACE: head_n = POS_W'(1);
      KIND_REPL:  head_n = POS_W'(cfg.rlen);
      default:    head_n = '0;
    endcase
    total_n   = head_n + POS_W'(q_data.flush_cnt) + POS_W'(q_data.last);
    flush_pos = pos_r - head_n;

    // head part, then the flushed window, then the newline
    item_last = 1'b0;
    if (pos_r < head_n) begin
      case (q_data.kind)
        KIND_CHAR:  item_char = q_data.head_char;
        KIND_SPACE: item_char = SPACE_CHAR;
        default:    item_char = cfg.repl[pos_r[$clog2(REPL_MAX)-1:0]];
      endcase
    end else if (pos_r < head_n + POS_W'(q_data.flush_cnt)) begin
      item_char = q_data.flush_bytes[flush_pos[$clog2(PATTERN_MAX)-1:0]];
    end else begin
      item_char = NEWLINE_CHAR;
      item_last = 1'b1;
    end

    busy          = !q_empty && (total_n == '0 || can_emit);
    q_pop         = 1'b0;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (busy) begin
      if (total_n != '0) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = item_char;
        out_last_nxt  = item_last;
      end
      if (total_n == '0 || pos_r + POS_W'(1) == total_n) begin
        q_pop   = 1'b1;
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

@@ rtl/substring_replace_stream.sv @@
// channel | dir | handshake         | payload
// in      | in  | in_tvalid/tready  | in_tdata: in_char; in_tlast: token_end
// out     | out | out_tvalid/tready | out_tdata: out_char; out_tlast: line_last
// cfg     | in  | cfg_valid/ready   | cfg_index: register; cfg_data: value
//
// the front end takes one character per cycle while the request queue has room
// the back end sends one character per cycle while the output is not stalled: a request
// emits one character for a plain character or space, replacement_length characters for a
// replacement, plus the flushed window and the newline at token end; a request with no output
// is popped without output. the queue depth (QUEUE_DEPTH) sets how far the input runs ahead
// reset is synchronous (rst_n low): window, queue and output register empty,
// registers back to their reset values. cfg_ready is always high
module substring_replace_stream #(
  parameter int QUEUE_DEPTH = srs_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [srs_pkg::CHAR_W-1:0]  in_tdata,   // [7:0] in_char
  input  logic                        in_tlast,   // token_end
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [srs_pkg::CHAR_W-1:0]  out_tdata,  // [7:0] out_char
  output logic                        out_tlast,  // line_last
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [srs_pkg::IDX_W-1:0]   cfg_index,
  input  logic [srs_pkg::WORD_W-1:0]  cfg_data
);
  import srs_pkg::*;

  logic [1:0]        mode_r;
  logic [PLEN_W-1:0] plen_r;
  logic [WORD_W-1:0] pattern_r;
  logic [RLEN_W-1:0] rlen_r;
  logic [WORD_W-1:0] rlow_r;
  logic [WORD_W-1:0] rhigh_r;

  cfg_t cfg;
  cmd_t q_in, q_out;
  logic q_push, q_pop, q_full, q_empty;
  logic cfg_wr, wnd_clear;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign wnd_clear = cfg_wr && (cfg_index == REG_PLEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_REPLACE;
      plen_r    <= PLEN_W'(1);
      pattern_r <= '0;
      rlen_r    <= '0;
      rlow_r    <= '0;
      rhigh_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_MODE:  mode_r    <= cfg_data[1:0];
        REG_PLEN:  plen_r    <= cfg_data[PLEN_W-1:0];
        REG_PAT:   pattern_r <= cfg_data;
        REG_RLEN:  rlen_r    <= cfg_data[RLEN_W-1:0];
        REG_RLOW:  rlow_r    <= cfg_data;
        REG_RHIGH: rhigh_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.mode    = mode_r;
    cfg.plen    = eff_plen(plen_r);
    cfg.pattern = pattern_r;
    cfg.rlen    = eff_rlen(rlen_r);
    cfg.repl    = {rhigh_r, rlow_r};
  end

  srs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg       (cfg),
    .wnd_clear (wnd_clear),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  srs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  srs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/srs_checker.sv @@
module srs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [srs_pkg::CHAR_W-1:0]  out_tdata,
  input logic                        out_tlast
);
  import srs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // the line end is always a newline
  a_last_newline: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == NEWLINE_CHAR)
    else $error("line end without newline");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind substring_replace_stream srs_checker u_srs_checker (.*);

@@ dv/tb_substring_replace_stream.sv @@
`timescale 1ns / 100ps

module tb_substring_replace_stream;
  import srs_pkg::*;

  localparam logic [1:0]       MODE_DELETE  = 2'd0;
  localparam logic [1:0]       MODE_DROP    = 2'd3;
  localparam logic [IDX_W-1:0] REG_SPARE_A  = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B  = 3'd7;
  localparam int               RUN_ITEMS    = 460;
  localparam int               CALM_ITEMS   = 400;
  localparam int               HOLD_AT      = 200;
  localparam int               HOLD_CYCLES  = 300;
  localparam int               SETTLE_GAP   = 40;
  localparam int               CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } line_char_t;

  typedef struct {
    bit                is_cfg;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] data;
    logic [CHAR_W-1:0] ch;
    logic              last;
    int                n_typed;  // -1: take results from the predictor
    logic [CHAR_W-1:0] t0;
    logic [CHAR_W-1:0] t1;
  } row_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [CHAR_W-1:0] in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [CHAR_W-1:0] out_tdata;
  logic              out_tlast;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index  = '0;
  logic [WORD_W-1:0] cfg_data   = '0;

  // predictor state
  logic [1:0]        m_mode;
  logic [PLEN_W-1:0] m_plen;
  logic [WORD_W-1:0] m_pat;
  logic [RLEN_W-1:0] m_rlen;
  logic [WORD_W-1:0] m_rlo;
  logic [WORD_W-1:0] m_rhi;
  logic [CHAR_W-1:0] win [PATTERN_MAX];
  int unsigned       win_n;

  line_char_t line_q[$];
  line_char_t scan_out[$];
  row_t       rows[$];
  int         items_sent = 0;
  int         n_bad      = 0;
  int         cycles     = 0;
  bit         calm       = 1'b0;

  substring_replace_stream u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned window_len();
    int unsigned n;
    n = m_plen;
    if (n == 0) n = 1;
    if (n > PATTERN_MAX) n = PATTERN_MAX;
    return n;
  endfunction

  function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] d);
    case (idx)
      REG_MODE: m_mode = d[1:0];
      REG_PLEN: begin
        m_plen = d[PLEN_W-1:0];
        win_n  = 0;
      end
      REG_PAT:   m_pat  = d;
      REG_RLEN:  m_rlen = d[RLEN_W-1:0];
      REG_RLOW:  m_rlo  = d;
      REG_RHIGH: m_rhi  = d;
      default: ;
    endcase
  endfunction

  // results caused by one character, left in scan_out
  function automatic void scan_char(input logic [CHAR_W-1:0] c, input logic tok_end);
    int unsigned plen;
    int unsigned rl;
    int unsigned i;
    bit          hit;
    plen = window_len();
    scan_out.delete();
    if (win_n < PATTERN_MAX) begin
      win[win_n] = c;
      win_n++;
    end
    if (win_n >= plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++)
        if (win[i] != m_pat[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        win_n = 0;
        if (m_mode == MODE_REPLACE) begin
          rl = (m_rlen > REPL_MAX) ? REPL_MAX : m_rlen;
          for (i = 0; i < rl; i++)
            scan_out.push_back({(i < 8) ? m_rlo[8*i +: 8] : m_rhi[8*(i-8) +: 8], 1'b0});
        end else if (m_mode == MODE_SPACE) begin
          scan_out.push_back({SPACE_CHAR, 1'b0});
        end
      end else begin
        scan_out.push_back({win[0], 1'b0});
        for (i = 1; i < win_n; i++) win[i-1] = win[i];
        win_n--;
      end
    end
    if (tok_end) begin
      for (i = 0; i < win_n; i++) scan_out.push_back({win[i], 1'b0});
      win_n = 0;
      scan_out.push_back({NEWLINE_CHAR, 1'b1});
    end
  endfunction

  function automatic row_t cfg_row(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] d);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = d;
    return r;
  endfunction

  function automatic row_t char_row(input logic [CHAR_W-1:0] c, input logic l, input int n,
                                    input logic [CHAR_W-1:0] t0, input logic [CHAR_W-1:0] t1);
    row_t r;
    r = '{default: '0};
    r.ch      = c;
    r.last    = l;
    r.n_typed = n;
    r.t0      = t0;
    r.t1      = t1;
    return r;
  endfunction

  // offers one character; n_typed < 0 takes the predicted results
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic l, input int n_typed,
                           input logic [CHAR_W-1:0] t0, input logic [CHAR_W-1:0] t1);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    calm = (items_sent >= CALM_ITEMS);
    scan_char(c, l);
    if (n_typed < 0) begin
      foreach (scan_out[k]) line_q.push_back(scan_out[k]);
    end else if (n_typed == 1) begin
      line_q.push_back({t0, l});
    end else if (n_typed == 2) begin
      line_q.push_back({t0, 1'b0});
      line_q.push_back({t1, l});
    end
  endtask

  // block idle: nothing expected and any request without output has drained
  task automatic settle();
    in_tvalid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, d);
  endtask

  // random pattern byte, biased to a small alphabet so tokens hit it
  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(0, 3) == 0) return CHAR_W'($urandom_range(0, 255));
    return CHAR_W'(8'h61 + $urandom_range(0, 3));
  endfunction

  // output side: random stalls plus one long hold-off to back up the queue
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && items_sent >= HOLD_AT && in_tvalid) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    line_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (line_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected char: got ch=%02h last=%0b", out_tdata, out_tlast);
      end else begin
        want = line_q.pop_front();
        if (out_tdata !== want.ch || out_tlast !== want.last) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: expected ch=%02h last=%0b, got ch=%02h last=%0b",
                     want.ch, want.last, out_tdata, out_tlast);
        end
      end
    end
  end

  initial begin
    bit                cfg_open;
    int                n_tok;
    int                tok_len;
    int                cut;
    int unsigned       plen;
    logic [WORD_W-1:0] pat;
    logic [CHAR_W-1:0] tok[$];
    int                r;

    m_mode = MODE_REPLACE;
    m_plen = PLEN_W'(1);
    m_pat  = '0;
    m_rlen = '0;
    m_rlo  = '0;
    m_rhi  = '0;
    foreach (win[k]) win[k] = '0;
    win_n    = 0;
    cfg_open = 1'b0;

    // directed part; characters 'a' = 61h, 'b' = 62h, 'c' = 63h
    rows.push_back(char_row(8'h41, 1'b1, 2, 8'h41, NEWLINE_CHAR));
    rows.push_back(char_row(8'h00, 1'b1, 1, NEWLINE_CHAR, 8'h00));   // zero matches reset pattern
    rows.push_back(char_row(8'hFF, 1'b1, 2, 8'hFF, NEWLINE_CHAR));
    rows.push_back(cfg_row(REG_MODE, WORD_W'(MODE_SPACE)));
    rows.push_back(cfg_row(REG_PLEN, 64'd3));
    rows.push_back(cfg_row(REG_PAT, 64'h0000_0000_0063_6261));
    rows.push_back(char_row(8'h61, 1'b0, -1, 8'h00, 8'h00));
    rows.push_back(char_row(8'h62, 1'b0, -1, 8'h00, 8'h00));
    rows.push_back(char_row(8'h63, 1'b0, -1, 8'h00, 8'h00));
    rows.push_back(char_row(8'h79, 1'b1, -1, 8'h00, 8'h00));
    // longest replacement, length register saturating
    rows.push_back(cfg_row(REG_MODE, WORD_W'(MODE_REPLACE)));
    rows.push_back(cfg_row(REG_RLOW, 64'hFFFF_FFFF_FFFF_FFFF));
    rows.push_back(cfg_row(REG_RHIGH, 64'h0123_4567_89AB_CDEF));
    rows.push_back(cfg_row(REG_RLEN, 64'd31));
    rows.push_back(char_row(8'h61, 1'b0, -1, 8'h00, 8'h00));
    rows.push_back(char_row(8'h62, 1'b0, -1, 8'h00, 8'h00));
    rows.push_back(char_row(8'h63, 1'b1, -1, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_MODE, WORD_W'(MODE_DELETE)));
    rows.push_back(char_row(8'h61, 1'b0, 0, 8'h00, 8'h00));
    rows.push_back(char_row(8'h62, 1'b0, 0, 8'h00, 8'h00));
    rows.push_back(char_row(8'h63, 1'b1, 1, NEWLINE_CHAR, 8'h00));
    // zero length acts as one
    rows.push_back(cfg_row(REG_MODE, WORD_W'(MODE_DROP)));
    rows.push_back(cfg_row(REG_PLEN, 64'd0));
    rows.push_back(char_row(8'h61, 1'b0, 0, 8'h00, 8'h00));
    rows.push_back(char_row(8'h62, 1'b1, 2, 8'h62, NEWLINE_CHAR));
    // oversized length clamps to the full window
    rows.push_back(cfg_row(REG_MODE, WORD_W'(MODE_SPACE)));
    rows.push_back(cfg_row(REG_PLEN, 64'd15));
    rows.push_back(cfg_row(REG_PAT, 64'hFFFF_FFFF_FFFF_FFFF));
    for (int k = 0; k < 7; k++) rows.push_back(char_row(8'hFF, 1'b0, 0, 8'h00, 8'h00));
    rows.push_back(char_row(8'hFF, 1'b1, 2, SPACE_CHAR, NEWLINE_CHAR));
    rows.push_back(cfg_row(REG_SPARE_A, 64'hDEAD_BEEF_0000_0001));
    rows.push_back(cfg_row(REG_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF));
    // length write mid token drops the held characters
    rows.push_back(char_row(8'h61, 1'b0, -1, 8'h00, 8'h00));
    rows.push_back(char_row(8'h62, 1'b0, -1, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_PLEN, 64'd2));
    rows.push_back(char_row(8'h63, 1'b1, -1, 8'h00, 8'h00));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        write_reg(rows[k].idx, rows[k].data);
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_char(rows[k].ch, rows[k].last, rows[k].n_typed, rows[k].t0, rows[k].t1);
      end
    end
    if (cfg_open) cfg_valid <= 1'b0;

    // random phases: fresh settings, then tokens rich in the pattern
    while (items_sent < RUN_ITEMS) begin
      settle();
      write_reg(REG_MODE, WORD_W'($urandom_range(0, 3)));
      r = $urandom_range(0, 9);
      if (r == 0) write_reg(REG_PLEN, 64'd0);
      else if (r == 1) write_reg(REG_PLEN, WORD_W'($urandom_range(8, 15)));
      else write_reg(REG_PLEN, WORD_W'($urandom_range(1, 4)));
      for (int k = 0; k < 8; k++) pat[8*k +: 8] = pick_char();
      write_reg(REG_PAT, pat);
      r = $urandom_range(0, 5);
      if (r == 0) write_reg(REG_RLEN, WORD_W'($urandom_range(17, 31)));
      else if (r == 1) write_reg(REG_RLEN, WORD_W'(REPL_MAX));
      else if (r == 2) write_reg(REG_RLEN, 64'd0);
      else write_reg(REG_RLEN, WORD_W'($urandom_range(1, 6)));
      write_reg(REG_RLOW, {$urandom(), $urandom()});
      write_reg(REG_RHIGH, {$urandom(), $urandom()});
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom(), $urandom()});
      cfg_valid <= 1'b0;

      plen  = window_len();
      n_tok = $urandom_range(3, 8);
      for (int t = 0; t < n_tok; t++) begin
        tok.delete();
        tok_len = $urandom_range(1, 14);
        while (tok.size() < tok_len) begin
          case ($urandom_range(0, 4))
            0, 1: for (int k = 0; k < plen; k++) tok.push_back(m_pat[8*k +: 8]);
            2: begin
              cut = $urandom_range(1, plen);
              for (int k = 0; k < cut; k++) tok.push_back(m_pat[8*k +: 8]);
            end
            3: tok.push_back(CHAR_W'(8'h61 + $urandom_range(0, 3)));
            default: tok.push_back(CHAR_W'($urandom_range(0, 255)));
          endcase
        end
        while (tok.size() > tok_len) void'(tok.pop_back());
        // now and then the phase ends inside a token
        cut = (t == n_tok - 1 && $urandom_range(0, 3) == 0);
        foreach (tok[k])
          send_char(tok[k], (k == tok.size() - 1) && !cut, -1, 8'h00, 8'h00);
      end
    end

    in_tvalid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_bad == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
